// ===== design/mfs_pkg.sv =====
package mfs_pkg;

  localparam int VALUE_COUNT = 256;
  localparam int CAPACITY    = 1024;

  localparam int VAL_W   = 8;
  localparam int VAL_AW  = $clog2(VALUE_COUNT);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int NODE_AW = $clog2(CAPACITY);

  localparam logic [CNT_W-1:0] NULL_NODE = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);

  localparam logic FN_PUSH = 1'b0;
  localparam logic FN_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== design/mfs_ram.sv =====
module mfs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mfs_step.sv =====
module mfs_step
  import mfs_pkg::*;
(
  input  logic [CNT_W-1:0] operand,
  input  logic             dec,
  output logic [CNT_W-1:0] result
);

  assign result = dec ? (operand - CNT_W'(1)) : (operand + CNT_W'(1));

endmodule

// ===== design/max_frequency_stack.sv =====
// Maximum-frequency stack. A request is taken when start is high and busy is
// low; func selects push of in_value or pop of the most frequent value (most
// recent among equals). A stored push passes through states P1 and P2 and
// gives no result; a pop passes through Q1, Q2 and Q3; a pop on an empty stack
// or a push into a full store gives its result in the cycle after it is taken.
// The states follow the chain of dependent reads through the single-read-port
// count, level-head and node memories, each with a registered read. Each result
// shows on out_popped_value and out_status for exactly one cycle with out_valid
// high; the receiver cannot stall the block, so results must be taken as they
// appear. No clearing pass is needed after reset.
module max_frequency_stack
  import mfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_func,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_popped_value,
  output logic [1:0]       out_status
);

  typedef enum logic [2:0] {S_IDLE, S_P1, S_P2, S_Q1, S_Q2, S_Q3} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  top_r, hw_r, free_head_r, fresh_r, stored_r;
  logic              cnt_vld_r [VALUE_COUNT];
  logic              cnt_hit_r, head_hit_r;
  logic [VAL_W-1:0]  value_r;
  logic [CNT_W-1:0]  lvl_r, node_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [1:0]        out_status_r;

  logic              accept;
  logic              value_ok;
  logic [CNT_W-1:0]  cnt_eff, head_eff, step_res, step_in;
  logic              step_dec;

  logic              cnt_we;
  logic [VAL_AW-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              lh_we;
  logic [NODE_AW-1:0] lh_waddr, lh_raddr;
  logic [CNT_W-1:0]  lh_wdata, lh_rdata;
  logic              nl_we;
  logic [NODE_AW-1:0] nl_waddr, nl_raddr;
  logic [CNT_W-1:0]  nl_wdata, nl_rdata;
  logic              nv_we;
  logic [NODE_AW-1:0] nv_waddr, nv_raddr;
  logic [VAL_W-1:0]  nv_rdata;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign value_ok = ({1'b0, in_value} < (VAL_W + 1)'(VALUE_COUNT));
  assign cnt_eff  = cnt_hit_r ? cnt_rdata : '0;
  assign head_eff = head_hit_r ? lh_rdata : NULL_NODE;

  assign step_dec = (state_r == S_Q3);
  assign step_in  = cnt_eff;

  mfs_step u_step (
    .operand (step_in),
    .dec     (step_dec),
    .result  (step_res)
  );

  mfs_ram #(.DEPTH(VALUE_COUNT), .WIDTH(CNT_W)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  mfs_ram #(.DEPTH(CAPACITY), .WIDTH(CNT_W)) u_head_ram (
    .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
    .raddr(lh_raddr), .rdata(lh_rdata)
  );

  mfs_ram #(.DEPTH(CAPACITY), .WIDTH(CNT_W)) u_link_ram (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(nl_raddr), .rdata(nl_rdata)
  );

  mfs_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_value_ram (
    .clk(clk), .we(nv_we), .waddr(nv_waddr), .wdata(value_r),
    .raddr(nv_raddr), .rdata(nv_rdata)
  );

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = value_r[VAL_AW-1:0];
    cnt_wdata = lvl_r;
    cnt_raddr = in_value[VAL_AW-1:0];
    lh_we     = 1'b0;
    lh_waddr  = lvl_r[NODE_AW-1:0] - NODE_AW'(1);
    lh_wdata  = node_r;
    lh_raddr  = top_r[NODE_AW-1:0] - NODE_AW'(1);
    nl_we     = 1'b0;
    nl_waddr  = node_r[NODE_AW-1:0];
    nl_wdata  = head_eff;
    nl_raddr  = free_head_r[NODE_AW-1:0];
    nv_we     = 1'b0;
    nv_waddr  = node_r[NODE_AW-1:0];
    nv_raddr  = node_r[NODE_AW-1:0];
    unique case (state_r)
      S_IDLE: ;
      S_P1: begin
        lh_raddr = step_res[NODE_AW-1:0] - NODE_AW'(1);
      end
      S_P2: begin
        cnt_we = 1'b1;
        lh_we  = 1'b1;
        nl_we  = 1'b1;
        nv_we  = 1'b1;
      end
      S_Q1: begin
        nl_raddr = lh_rdata[NODE_AW-1:0];
        nv_raddr = lh_rdata[NODE_AW-1:0];
      end
      S_Q2: begin
        lh_we     = 1'b1;
        lh_waddr  = top_r[NODE_AW-1:0] - NODE_AW'(1);
        lh_wdata  = nl_rdata;
        nl_we     = 1'b1;
        nl_wdata  = free_head_r;
        cnt_raddr = nv_rdata[VAL_AW-1:0];
      end
      S_Q3: begin
        cnt_we    = (cnt_eff != '0);
        cnt_wdata = step_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      hw_r        <= '0;
      free_head_r <= NULL_NODE;
      fresh_r     <= '0;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < VALUE_COUNT; i++) begin
        cnt_vld_r[i] <= 1'b0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cnt_we) begin
        cnt_vld_r[cnt_waddr] <= 1'b1;
      end
      cnt_hit_r <= cnt_vld_r[cnt_raddr];
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            value_r <= in_value;
            if (in_func == FN_PUSH) begin
              if (value_ok) begin
                if (stored_r >= CAP_CNT) begin
                  out_valid_r  <= 1'b1;
                  out_value_r  <= '0;
                  out_status_r <= ST_FULL;
                end else begin
                  state_r <= S_P1;
                end
              end
            end else if (top_r == '0) begin
              out_valid_r  <= 1'b1;
              out_value_r  <= '0;
              out_status_r <= ST_EMPTY;
            end else begin
              state_r <= S_Q1;
            end
          end
        end
        S_P1: begin
          lvl_r      <= step_res;
          head_hit_r <= (step_res <= hw_r);
          if (free_head_r != NULL_NODE) begin
            node_r      <= free_head_r;
            free_head_r <= nl_rdata;
          end else begin
            node_r  <= fresh_r;
            fresh_r <= fresh_r + CNT_W'(1);
          end
          state_r <= S_P2;
        end
        S_P2: begin
          stored_r <= stored_r + CNT_W'(1);
          if (lvl_r > top_r) begin
            top_r <= lvl_r;
          end
          if (lvl_r > hw_r) begin
            hw_r <= lvl_r;
          end
          state_r <= S_IDLE;
        end
        S_Q1: begin
          node_r  <= lh_rdata;
          state_r <= S_Q2;
        end
        S_Q2: begin
          value_r     <= nv_rdata;
          free_head_r <= node_r;
          stored_r    <= stored_r - CNT_W'(1);
          if (nl_rdata == NULL_NODE) begin
            top_r <= top_r - CNT_W'(1);
          end
          state_r <= S_Q3;
        end
        S_Q3: begin
          out_valid_r  <= 1'b1;
          out_value_r  <= value_r;
          out_status_r <= ST_OK;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_status       = out_status_r;

`ifndef SYNTH
  a_top_below_hw: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= hw_r) else $error("top level above highest written level");

  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CAP_CNT) else $error("stored total above capacity");

  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r == '0) == (stored_r == '0)) else $error("top level and total disagree");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q3) |=> (out_valid && out_status == ST_OK))
    else $error("pop did not deliver a result");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P1 || state_r == S_P2) |=> !out_valid)
    else $error("stored push gave a result");
`endif

endmodule

// ===== tb/sv/max_frequency_stack_checker.sv =====
module max_frequency_stack_checker
  import mfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic             in_func,
  input  logic [VAL_W-1:0] in_value,
  input  logic             out_valid,
  input  logic [VAL_W-1:0] out_popped_value,
  input  logic [1:0]       out_status,
  output int               fail_count,
  output int               pending,
  output int               results_seen,
  output int               full_seen,
  output int               empty_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
  } reply_t;

  reply_t reply_q[$];

  logic [CNT_W-1:0] freq_of    [VALUE_COUNT];
  logic [CNT_W-1:0] level_head [CAPACITY];
  logic [VAL_W-1:0] node_val   [CAPACITY];
  logic [CNT_W-1:0] node_next  [CAPACITY];
  logic [CNT_W-1:0] top_lvl;
  logic [CNT_W-1:0] free_list;
  logic [CNT_W-1:0] fresh_node;
  logic [CNT_W-1:0] in_use;

  int errs;
  int n_results;
  int n_full;
  int n_empty;

  function automatic void clear_stack();
    for (int i = 0; i < VALUE_COUNT; i++) freq_of[i] = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      level_head[i] = NULL_NODE;
      node_val[i]   = '0;
      node_next[i]  = '0;
    end
    top_lvl    = '0;
    free_list  = NULL_NODE;
    fresh_node = '0;
    in_use     = '0;
  endfunction

  function automatic void predict_stack_op(input logic fn, input logic [VAL_W-1:0] v);
    logic [CNT_W-1:0] node;
    logic [CNT_W-1:0] lvl;
    logic [CNT_W-1:0] nxt;
    reply_t r;
    r.value  = '0;
    r.status = ST_OK;
    if (fn == FN_PUSH) begin
      if (in_use >= CAP_CNT) begin
        r.status = ST_FULL;
        reply_q.push_back(r);
        return;
      end
      if (free_list != NULL_NODE) begin
        node      = free_list;
        free_list = node_next[node[NODE_AW-1:0]];
      end else begin
        node       = fresh_node;
        fresh_node = fresh_node + CNT_W'(1);
      end
      lvl = freq_of[v] + CNT_W'(1);
      freq_of[v] = lvl;
      node_val[node[NODE_AW-1:0]]  = v;
      node_next[node[NODE_AW-1:0]] = level_head[NODE_AW'(lvl - CNT_W'(1))];
      level_head[NODE_AW'(lvl - CNT_W'(1))] = node;
      in_use = in_use + CNT_W'(1);
      if (lvl > top_lvl) top_lvl = lvl;
      return;
    end
    if (top_lvl == '0) begin
      r.status = ST_EMPTY;
      reply_q.push_back(r);
      return;
    end
    node = level_head[NODE_AW'(top_lvl - CNT_W'(1))];
    r.value = node_val[node[NODE_AW-1:0]];
    nxt = node_next[node[NODE_AW-1:0]];
    level_head[NODE_AW'(top_lvl - CNT_W'(1))] = nxt;
    if (freq_of[r.value] != '0) freq_of[r.value] = freq_of[r.value] - CNT_W'(1);
    node_next[node[NODE_AW-1:0]] = free_list;
    free_list = node;
    if (in_use != '0) in_use = in_use - CNT_W'(1);
    if (nxt == NULL_NODE) top_lvl = top_lvl - CNT_W'(1);
    reply_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      clear_stack();
      reply_q.delete();
      errs      = 0;
      n_results = 0;
      n_full    = 0;
      n_empty   = 0;
    end else begin
      if (start && !busy) predict_stack_op(in_func, in_value);
      if (out_valid) begin
        n_results++;
        if (reply_q.size() == 0) begin
          $error("result with no request waiting: popped_value %0d, status %0d",
                 out_popped_value, out_status);
          errs++;
        end else begin
          want = reply_q.pop_front();
          if (out_popped_value !== want.value) begin
            $error("popped_value mismatch: expected %0d, got %0d",
                   want.value, out_popped_value);
            errs++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_EMPTY) n_empty++;
        end
      end
    end
    fail_count   <= errs;
    pending      <= reply_q.size();
    results_seen <= n_results;
    full_seen    <= n_full;
    empty_seen   <= n_empty;
  end

endmodule

// ===== tb/sv/max_frequency_stack_tb.sv =====
module max_frequency_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfs_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_func;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic [VAL_W-1:0] out_popped_value;
  logic [1:0]       out_status;

  int fail_count;
  int pending;
  int results_seen;
  int full_seen;
  int empty_seen;
  int issued;
  int burst_left;
  int quiet;

  max_frequency_stack u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status)
  );

  max_frequency_stack_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen),
    .full_seen        (full_seen),
    .empty_seen       (empty_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no request taken and no result for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("** max_frequency_stack: FAILED **");
      $finish;
    end
  end

  task automatic issue(input logic fn, input logic [VAL_W-1:0] v);
    @(negedge clk);
    start    <= 1'b1;
    in_func  <= fn;
    in_value <= v;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  task automatic rest(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // bursts of back-to-back requests with random gaps between them
  task automatic issue_paced(input logic fn, input logic [VAL_W-1:0] v);
    issue(fn, v);
    burst_left--;
    if (burst_left <= 0) begin
      rest(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_traffic(input int n, input int pop_pct, input int pool);
    logic             fn;
    logic [VAL_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      fn = ($urandom_range(0, 99) < pop_pct) ? FN_POP : FN_PUSH;
      if (pool > 0 && $urandom_range(0, 3) != 0) v = VAL_W'($urandom_range(0, pool - 1));
      else v = VAL_W'($urandom_range(0, 255));
      issue_paced(fn, v);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_func    = FN_PUSH;
    in_value   = '0;
    issued     = 0;
    burst_left = 4;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty pop, extremes, frequency order and ties
    issue(FN_POP, 8'hFF);
    issue(FN_PUSH, 8'h00);
    issue(FN_PUSH, 8'hFF);
    issue(FN_PUSH, 8'h00);
    issue(FN_POP, 8'h00);
    issue(FN_POP, 8'hFF);
    issue(FN_POP, 8'h00);
    issue(FN_POP, 8'h00);
    rest(3);
    issue(FN_PUSH, 8'h55);
    issue(FN_PUSH, 8'hAA);
    issue(FN_PUSH, 8'h55);
    issue(FN_PUSH, 8'hAA);
    issue(FN_PUSH, 8'h01);
    issue(FN_POP, 8'hAA);
    issue(FN_POP, 8'h55);
    issue(FN_PUSH, 8'hAA);
    issue(FN_POP, 8'h00);
    issue(FN_POP, 8'hFF);
    issue(FN_POP, 8'h00);
    issue(FN_POP, 8'hFF);
    issue(FN_POP, 8'h00);
    issue(FN_POP, 8'h00);
    settle();

    // one value stacked deep, then drained past empty
    for (int i = 0; i < 100; i++) issue_paced(FN_PUSH, 8'h80);
    issue_paced(FN_PUSH, 8'h00);
    issue_paced(FN_PUSH, 8'hFF);
    for (int i = 0; i < 104; i++) issue_paced(FN_POP, VAL_W'($urandom_range(0, 255)));
    settle();

    // random mix with frequent repeats
    random_traffic(140, 40, 8);
    settle();
    random_traffic(130, 55, 4);
    settle();

    $display("%0d requests issued; %0d results checked (%0d empty pops, %0d full pushes)",
             issued, results_seen, empty_seen, full_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("** max_frequency_stack: PASSED **");
    end else begin
      $display("** max_frequency_stack: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mfs_pkg.sv
design/mfs_ram.sv
design/mfs_step.sv
design/max_frequency_stack.sv
tb/sv/max_frequency_stack_checker.sv
tb/sv/max_frequency_stack_tb.sv
